### hdl/signed_int_to_ascii_digits_unit_defines.svh
// ---------------------------------------------------------------------------
// signed_int_to_ascii_digits_unit_defines.svh
// Assertion macros used by the checker of the integer-to-text unit.
// ---------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_ASCII_DIGITS_UNIT_DEFINES_SVH
`define SIGNED_INT_TO_ASCII_DIGITS_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SITOA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SITOA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sitoa_pkg.sv
// ---------------------------------------------------------------------------
// sitoa_pkg
// Types, sizes and character codes of the integer-to-text unit.
// ---------------------------------------------------------------------------
`default_nettype none

package sitoa_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int CHAR_W      = 7;

    // Magnitude of the most negative value needs the full width unsigned.
    localparam int MAG_W       = VALUE_WIDTH;
    localparam int DEC_DIGITS  = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int HEX_DIGITS  = (VALUE_WIDTH + 3) / 4;
    localparam int NUM_DIGITS  = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int DEC_W       = DEC_DIGITS * 4;
    localparam int DIGITS_W    = NUM_DIGITS * 4;
    localparam int STEPS       = HEX_DIGITS;
    localparam int PAD_W       = STEPS * 4;
    localparam int STEP_W      = $clog2(STEPS);
    localparam int IDX_W       = $clog2(NUM_DIGITS);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'd57;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'd97;
    localparam logic [CHAR_W-1:0] CHAR_F     = 7'd102;

    localparam logic [CHAR_W-1:0] DIGIT_CODES [16] = '{
        7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55,
        7'd56, 7'd57, 7'd97, 7'd98, 7'd99, 7'd100, 7'd101, 7'd102
    };

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          hex_mode;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } out_item_t;

    // Request after classification: magnitude, sign and base.
    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic             hex;
    } class_item_t;

    // Converted digits handed from converter to emitter.
    typedef struct packed {
        logic                valid;
        logic                neg;
        logic [IDX_W-1:0]    msd;
        logic [DIGITS_W-1:0] digits;
    } conv_res_t;

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_RUN,
        CONV_HOLD
    } conv_state_t;

    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_SIGN,
        EMIT_DIGIT
    } emit_state_t;

endpackage

`default_nettype wire

### hdl/sitoa_front.sv
// ---------------------------------------------------------------------------
// sitoa_front
// Classify a request: sign, magnitude and base.
// ---------------------------------------------------------------------------
`default_nettype none

module sitoa_front
    import sitoa_pkg::*;
(
    input  in_item_t    item,
    output class_item_t cls
);

    logic             neg;
    logic [MAG_W-1:0] raw;

    assign raw = MAG_W'(item.value);
    assign neg = raw[MAG_W-1];

    // Two's complement negate; the most negative value wraps to its magnitude.
    assign cls.mag = neg ? (~raw + 1'b1) : raw;
    assign cls.neg = neg;
    assign cls.hex = item.hex_mode;

endmodule

`default_nettype wire

### hdl/sitoa_queue.sv
// ---------------------------------------------------------------------------
// sitoa_queue
// Two-entry queue of classified requests between front and converter.
// ---------------------------------------------------------------------------
`default_nettype none

module sitoa_queue
    import sitoa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  class_item_t push_item,
    input  logic        pop,
    output logic        full,
    output logic        head_valid,
    output class_item_t head_item
);

    class_item_t ent0_reg, ent0_next;
    class_item_t ent1_reg, ent1_next;
    logic [1:0]  count_reg, count_next;

    always_comb
    begin
        ent0_next  = ent0_reg;
        ent1_next  = ent1_reg;
        count_next = count_reg;
        if (push && pop)
        begin
            // Advance head and refill behind it.
            if (count_reg == 2'd1)
            begin
                ent0_next = push_item;
            end
            else
            begin
                ent0_next = ent1_reg;
                ent1_next = push_item;
            end
        end
        else if (pop)
        begin
            ent0_next  = ent1_reg;
            count_next = count_reg - 2'd1;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                ent0_next = push_item;
            end
            else
            begin
                ent1_next = push_item;
            end
            count_next = count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = ent0_reg;

endmodule

`default_nettype wire

### hdl/sitoa_conv.sv
// ---------------------------------------------------------------------------
// sitoa_conv
// Turn a magnitude into digit nibbles: shift-add-3 binary to BCD, four
// bits a cycle, or a direct nibble split in hex mode.
// ---------------------------------------------------------------------------
`default_nettype none

module sitoa_conv
    import sitoa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  class_item_t q_item,
    output logic        q_pop,
    output conv_res_t   res,
    input  logic        res_take
);

    conv_state_t         state_reg, state_next;
    logic [PAD_W-1:0]    mag_reg, mag_next;
    logic [DIGITS_W-1:0] digit_reg, digit_next;
    logic                neg_reg, neg_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [IDX_W-1:0]    msd;

    // Shift four bits into the BCD word, correcting digits before each shift.
    function automatic logic [DEC_W-1:0] dd_step(input logic [DEC_W-1:0] bcd_in,
                                                 input logic [3:0] bits);
        logic [DEC_W-1:0] bcd;
        bcd = bcd_in;
        for (int b = 3; b >= 0; b--)
        begin
            for (int i = 0; i < DEC_DIGITS; i++)
            begin
                if (bcd[i*4 +: 4] >= 4'd5)
                begin
                    bcd[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
                end
            end
            bcd = {bcd[DEC_W-2:0], bits[b]};
        end
        return bcd;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CONV_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_item.hex ? CONV_HOLD : CONV_RUN;
                end
            end
            CONV_RUN:
            begin
                if (step_reg == '0)
                begin
                    state_next = CONV_HOLD;
                end
            end
            CONV_HOLD:
            begin
                if (res_take)
                begin
                    state_next = CONV_IDLE;
                end
            end
            default:
            begin
                state_next = CONV_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop      = 1'b0;
        mag_next   = mag_reg;
        digit_next = digit_reg;
        neg_next   = neg_reg;
        step_next  = step_reg;
        unique case (state_reg)
            CONV_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    mag_next   = PAD_W'(q_item.mag);
                    neg_next   = q_item.neg;
                    step_next  = STEP_W'(STEPS - 1);
                    digit_next = q_item.hex ? DIGITS_W'(q_item.mag) : '0;
                end
            end
            CONV_RUN:
            begin
                digit_next[DEC_W-1:0] = dd_step(digit_reg[DEC_W-1:0],
                                                mag_reg[PAD_W-1 -: 4]);
                mag_next  = mag_reg << 4;
                step_next = step_reg - 1'b1;
            end
            CONV_HOLD:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Most significant nonzero digit; zero points at the units digit.
    always_comb
    begin
        msd = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (digit_reg[i*4 +: 4] != 4'd0)
            begin
                msd = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CONV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        digit_reg <= digit_next;
        neg_reg   <= neg_next;
        step_reg  <= step_next;
    end

    assign res.valid  = (state_reg == CONV_HOLD);
    assign res.neg    = neg_reg;
    assign res.msd    = msd;
    assign res.digits = digit_reg;

endmodule

`default_nettype wire

### hdl/sitoa_emit.sv
// ---------------------------------------------------------------------------
// sitoa_emit
// Send the sign and digits as ASCII, most significant first, one a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module sitoa_emit
    import sitoa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  conv_res_t res,
    output logic      take,
    output logic      strobe,
    output out_item_t result
);

    emit_state_t         state_reg, state_next;
    logic [DIGITS_W-1:0] digit_reg, digit_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                strobe_reg, strobe_next;
    out_item_t           result_reg, result_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            EMIT_IDLE:
            begin
                if (res.valid)
                begin
                    state_next = res.neg ? EMIT_SIGN : EMIT_DIGIT;
                end
            end
            EMIT_SIGN:
            begin
                state_next = EMIT_DIGIT;
            end
            EMIT_DIGIT:
            begin
                if (idx_reg == '0)
                begin
                    state_next = EMIT_IDLE;
                end
            end
            default:
            begin
                state_next = EMIT_IDLE;
            end
        endcase
    end

    always_comb
    begin
        take        = 1'b0;
        digit_next  = digit_reg;
        idx_next    = idx_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            EMIT_IDLE:
            begin
                if (res.valid)
                begin
                    take       = 1'b1;
                    digit_next = res.digits;
                    idx_next   = res.msd;
                end
            end
            EMIT_SIGN:
            begin
                strobe_next           = 1'b1;
                result_next.character = CHAR_MINUS;
                result_next.last      = 1'b0;
            end
            EMIT_DIGIT:
            begin
                strobe_next           = 1'b1;
                result_next.character = DIGIT_CODES[digit_reg[{idx_reg, 2'b00} +: 4]];
                result_next.last      = (idx_reg == '0);
                idx_next              = idx_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= EMIT_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg  <= digit_next;
        idx_reg    <= idx_next;
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### hdl/signed_int_to_ascii_digits_unit.sv
// ---------------------------------------------------------------------------
// signed_int_to_ascii_digits_unit
// Signed integer to ASCII text in base ten or sixteen, one character a cycle while a number is sent.
// ---------------------------------------------------------------------------
// Usage:
//   Drive item (value, hex_mode) and raise start; the request is taken at a
//   rising edge where start is high and busy is low. busy rises only when
//   the two-entry request queue is full.
//   Each character appears on result for exactly one cycle with strobe high:
//   an optional '-', then the magnitude's digits, most significant first,
//   lower-case hex letters. last marks the final character of each number.
//   The receiver cannot stall; it must take every strobed character.
// Path: a request passes through the queue, converter, emitter and output
//   register before its first character appears.
// Flow: the decimal converter shifts 4 bits of the magnitude a cycle through
//   shift-add-3, after a load and before its hand-off; hex mode skips the
//   shifting. The emitter loads a result, then sends one character a cycle.
//   The converter can take the next request while the emitter is still
//   sending the previous number.
// Reset: asynchronous, active low; empties the queue, idles converter and
//   emitter and drops strobe. Nothing else needs clearing.
// ---------------------------------------------------------------------------
`default_nettype none

module signed_int_to_ascii_digits_unit
    import sitoa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  item,
    output logic      strobe,
    output out_item_t result
);

    class_item_t cls;
    class_item_t head_item;
    logic        push;
    logic        full;
    logic        head_valid;
    logic        pop;
    conv_res_t   conv_res;
    logic        conv_take;

    // Classify the incoming request: sign, magnitude, base.
    sitoa_front u_front (
        .item (item),
        .cls  (cls)
    );

    // Accept a request whenever the queue has room.
    assign push = start && !full;
    assign busy = full;

    // Hold up to two classified requests so the front waits on conversion only when the queue is full.
    sitoa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (cls),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Produce digit nibbles; the result waits here until the emitter loads it.
    sitoa_conv u_conv (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (head_valid),
        .q_item   (head_item),
        .q_pop    (pop),
        .res      (conv_res),
        .res_take (conv_take)
    );

    // Stream characters from a registered output while the next one converts.
    sitoa_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .res    (conv_res),
        .take   (conv_take),
        .strobe (strobe),
        .result (result)
    );

endmodule

`default_nettype wire

### hdl/sitoa_checker.sv
// ---------------------------------------------------------------------------
// sitoa_checker
// Port-level checks on the character stream of the integer-to-text unit.
// ---------------------------------------------------------------------------
`default_nettype none

`include "signed_int_to_ascii_digits_unit_defines.svh"

module sitoa_checker
    import sitoa_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      strobe,
    input out_item_t result
);

    logic is_minus;
    logic is_char;

    assign is_minus = (result.character == CHAR_MINUS);
    assign is_char  = ((result.character >= CHAR_ZERO) && (result.character <= CHAR_NINE))
                   || ((result.character >= CHAR_A) && (result.character <= CHAR_F))
                   || is_minus;

    `SITOA_ASSERT_NOW(a_char_legal, strobe, is_char, "illegal character code")
    `SITOA_ASSERT_NOW(a_minus_not_last, strobe && is_minus, !result.last, "minus marked last")
    `SITOA_ASSERT_NEXT(a_minus_then_digit, strobe && is_minus, strobe && !is_minus, "no digit after minus")
    `SITOA_ASSERT_NEXT(a_gap_after_last, strobe && result.last, !strobe, "character right after last")

endmodule

bind signed_int_to_ascii_digits_unit sitoa_checker u_sitoa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .strobe (strobe),
    .result (result)
);

`default_nettype wire
